### rtl/core/lrufac_pkg.sv
// lrufac_pkg: shared constants and controller/datapath interface types
// for the lru fully associative cache core
// no dependencies
`default_nettype none

package lrufac_pkg;

    localparam int ADDR_W = 64;
    localparam int OUT_W  = 32;
    localparam int CFG_W  = 9;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    // command codes
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // datapath sweep modes
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_IDLE   = 2'd0;
    localparam mode_t MODE_SCAN   = 2'd1;
    localparam mode_t MODE_UPDATE = 2'd2;
    localparam mode_t MODE_CLEAR  = 2'd3;

    typedef struct packed {
        logic  accept;
        logic  sweep_start;
        mode_t mode;
        logic  finish;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_done;
    } dp_sts_t;

endpackage

`default_nettype wire

### rtl/core/lrufac_ctrl.sv
// lrufac_ctrl: sequencing state machine for the lru cache core
// depends on lrufac_pkg (command codes, dp_cmd_t, dp_sts_t)
`default_nettype none

module lrufac_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                command,
    output logic                     busy,
    output lrufac_pkg::dp_cmd_t      cmd,
    input  wire lrufac_pkg::dp_sts_t sts
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_CLEAR  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd.accept      = 1'b0;
        cmd.sweep_start = 1'b0;
        cmd.mode        = lrufac_pkg::MODE_IDLE;
        cmd.finish      = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                // invalidate every line after reset
                cmd.mode = lrufac_pkg::MODE_CLEAR;
                if (sts.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept      = 1'b1;
                    cmd.sweep_start = 1'b1;
                    if (command == lrufac_pkg::CMD_ACCESS)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.mode = lrufac_pkg::MODE_SCAN;
                if (sts.sweep_done)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.mode = lrufac_pkg::MODE_UPDATE;
                if (sts.sweep_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                cmd.mode = lrufac_pkg::MODE_CLEAR;
                if (sts.sweep_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

### rtl/core/lrufac_dp.sv
// lrufac_dp: line memory, sweep counter, search and recency update, counters
// depends on lrufac_pkg (widths, codes, dp_cmd_t, dp_sts_t)
`default_nettype none

module lrufac_dp #(
    parameter int LINES       = 256,
    parameter int OFFSET_BITS = 6,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              command,
    input  wire logic [lrufac_pkg::ADDR_W-1:0]     address,
    input  wire logic                              max_lines_we,
    input  wire logic [lrufac_pkg::CFG_W-1:0]      max_lines,
    input  wire lrufac_pkg::dp_cmd_t               cmd,
    output lrufac_pkg::dp_sts_t                    sts,
    output logic                                   done,
    output logic                                   hit,
    output logic [lrufac_pkg::OUT_W-1:0]           access_total,
    output logic [lrufac_pkg::OUT_W-1:0]           miss_total
);

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CNT_W = $clog2(LINES + 1);
    localparam int TAG_W = lrufac_pkg::ADDR_W - OFFSET_BITS;
    localparam int CAP_W = (CNT_W > lrufac_pkg::CFG_W) ? CNT_W : lrufac_pkg::CFG_W;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] rank;
        logic [TAG_W-1:0] tag;
    } entry_t;

    entry_t mem [LINES];
    entry_t rd_data_reg;
    entry_t wr_data;
    entry_t upd_data;

    logic [CNT_W-1:0]            rd_idx_reg;
    logic [IDX_W-1:0]            rd_addr;
    logic [IDX_W-1:0]            wr_addr;
    logic                        wr_en;
    logic                        rd_en;
    logic                        sweep_end;
    logic                        clr_wr;
    logic                        scan_v;
    logic                        upd_wr;
    logic                        p_valid_reg;
    logic [IDX_W-1:0]            p_idx_reg;

    logic [TAG_W-1:0]            tag_reg;
    logic                        clr_reg;
    logic                        found_reg;
    logic [IDX_W-1:0]            found_idx_reg;
    logic [IDX_W-1:0]            found_rank_reg;
    logic                        inv_found_reg;
    logic [IDX_W-1:0]            inv_idx_reg;
    logic [IDX_W-1:0]            victim_idx_reg;

    logic [CNT_W-1:0]            used_reg;
    logic [IDX_W-1:0]            used_m1;
    logic [COUNT_BITS-1:0]       acc_cnt_reg;
    logic [COUNT_BITS-1:0]       acc_cnt_next;
    logic [COUNT_BITS-1:0]       miss_cnt_reg;
    logic [COUNT_BITS-1:0]       miss_cnt_next;
    logic [lrufac_pkg::CFG_W-1:0] max_lines_reg;
    logic                        hit_reg;
    logic                        done_reg;

    logic [CAP_W-1:0]            cfg_ext;
    logic [CAP_W-1:0]            cap;
    logic                        evict;
    logic [IDX_W-1:0]            slot;

    // sweep sequencing
    assign sweep_end = (rd_idx_reg == CNT_W'(LINES));
    assign rd_addr   = rd_idx_reg[IDX_W-1:0];
    assign rd_en     = ((cmd.mode == lrufac_pkg::MODE_SCAN) ||
                        (cmd.mode == lrufac_pkg::MODE_UPDATE)) &&
                       !cmd.sweep_start && !sweep_end;
    assign clr_wr    = (cmd.mode == lrufac_pkg::MODE_CLEAR) && !sweep_end;
    assign scan_v    = (cmd.mode == lrufac_pkg::MODE_SCAN) && p_valid_reg;
    assign upd_wr    = (cmd.mode == lrufac_pkg::MODE_UPDATE) && p_valid_reg;
    assign sts.sweep_done = sweep_end && !p_valid_reg;

    // capacity, clamped to 1..LINES
    always_comb
    begin
        cfg_ext = CAP_W'(max_lines_reg);
        if (cfg_ext == '0)
        begin
            cap = CAP_W'(1);
        end
        else if (cfg_ext > CAP_W'(LINES))
        begin
            cap = CAP_W'(LINES);
        end
        else
        begin
            cap = cfg_ext;
        end
    end

    assign evict   = (CAP_W'(used_reg) >= cap);
    assign used_m1 = IDX_W'(used_reg - CNT_W'(1));

    // freed victim slot may sit before the first empty one
    assign slot = (evict && (!inv_found_reg || (victim_idx_reg < inv_idx_reg))) ?
                  victim_idx_reg : inv_idx_reg;

    // recency rewrite of the entry read in the previous cycle
    always_comb
    begin
        upd_data = rd_data_reg;
        if (found_reg)
        begin
            if (p_idx_reg == found_idx_reg)
            begin
                upd_data.rank = '0;
            end
            else if (rd_data_reg.valid && (rd_data_reg.rank < found_rank_reg))
            begin
                upd_data.rank = rd_data_reg.rank + IDX_W'(1);
            end
        end
        else
        begin
            if (p_idx_reg == slot)
            begin
                upd_data.valid = 1'b1;
                upd_data.rank  = '0;
                upd_data.tag   = tag_reg;
            end
            else if (evict && (p_idx_reg == victim_idx_reg))
            begin
                upd_data.valid = 1'b0;
            end
            else if (rd_data_reg.valid)
            begin
                upd_data.rank = rd_data_reg.rank + IDX_W'(1);
            end
        end
    end

    assign wr_en   = clr_wr || upd_wr;
    assign wr_addr = clr_wr ? rd_addr : p_idx_reg;
    assign wr_data = clr_wr ? entry_t'('0) : upd_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            p_idx_reg   <= rd_addr;
        end
    end

    // saturating counters
    assign acc_cnt_next  = (acc_cnt_reg == '1) ? acc_cnt_reg : acc_cnt_reg + COUNT_BITS'(1);
    assign miss_cnt_next = (miss_cnt_reg == '1) ? miss_cnt_reg : miss_cnt_reg + COUNT_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            p_valid_reg   <= 1'b0;
            found_reg     <= 1'b0;
            inv_found_reg <= 1'b0;
            clr_reg       <= 1'b0;
            used_reg      <= '0;
            acc_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            max_lines_reg <= lrufac_pkg::CFG_RESET;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_start)
            begin
                rd_idx_reg <= '0;
            end
            else if (rd_en || clr_wr)
            begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
            p_valid_reg <= rd_en;

            if (max_lines_we)
            begin
                max_lines_reg <= max_lines;
            end

            if (cmd.accept)
            begin
                clr_reg       <= (command == lrufac_pkg::CMD_CLEAR);
                found_reg     <= 1'b0;
                inv_found_reg <= 1'b0;
            end
            else if (scan_v)
            begin
                if (rd_data_reg.valid && (rd_data_reg.tag == tag_reg))
                begin
                    found_reg <= 1'b1;
                end
                if (!rd_data_reg.valid)
                begin
                    inv_found_reg <= 1'b1;
                end
            end

            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                if (clr_reg)
                begin
                    used_reg     <= '0;
                    acc_cnt_reg  <= '0;
                    miss_cnt_reg <= '0;
                end
                else
                begin
                    acc_cnt_reg <= acc_cnt_next;
                    if (!found_reg)
                    begin
                        miss_cnt_reg <= miss_cnt_next;
                        if (!evict)
                        begin
                            used_reg <= used_reg + CNT_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            tag_reg <= address[lrufac_pkg::ADDR_W-1:OFFSET_BITS];
        end
        if (scan_v)
        begin
            if (rd_data_reg.valid && (rd_data_reg.tag == tag_reg) && !found_reg)
            begin
                found_idx_reg  <= p_idx_reg;
                found_rank_reg <= rd_data_reg.rank;
            end
            if (!rd_data_reg.valid && !inv_found_reg)
            begin
                inv_idx_reg <= p_idx_reg;
            end
            // least recent line carries the highest rank
            if (rd_data_reg.valid && (rd_data_reg.rank == used_m1))
            begin
                victim_idx_reg <= p_idx_reg;
            end
        end
        if (cmd.finish)
        begin
            hit_reg <= !clr_reg && found_reg;
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign access_total = lrufac_pkg::OUT_W'(acc_cnt_reg);
    assign miss_total   = lrufac_pkg::OUT_W'(miss_cnt_reg);

endmodule

`default_nettype wire

### rtl/core/lru_fully_associative_cache_core.sv
// lru_fully_associative_cache_core: top level of the lru cache tag store
// depends on lrufac_pkg, lrufac_ctrl, lrufac_dp
`default_nettype none

// A word is taken at the clock edge where start is high and busy is low. An access
// makes two passes over the line memory, a tag search and then a recency
// rewrite, one entry per cycle each, and the result appears with done in the
// cycle where busy falls; busy is already low while done is shown. A clear
// command rewrites every line. After reset the same invalidation pass runs with
// busy high. Results are shown for one cycle only and cannot be held off.
// max_lines may be written whenever the core is idle.
module lru_fully_associative_cache_core #(
    parameter int LINES       = 256,
    parameter int OFFSET_BITS = 6,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          command,
    input  wire logic [lrufac_pkg::ADDR_W-1:0] address,
    output logic                               done,
    output logic                               hit,
    output logic [lrufac_pkg::OUT_W-1:0]       access_total,
    output logic [lrufac_pkg::OUT_W-1:0]       miss_total,
    input  wire logic                          max_lines_we,
    input  wire logic [lrufac_pkg::CFG_W-1:0]  max_lines
);

    lrufac_pkg::dp_cmd_t cmd;
    lrufac_pkg::dp_sts_t sts;

    lrufac_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .cmd     (cmd),
        .sts     (sts)
    );

    lrufac_dp #(
        .LINES       (LINES),
        .OFFSET_BITS (OFFSET_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .address      (address),
        .max_lines_we (max_lines_we),
        .max_lines    (max_lines),
        .cmd          (cmd),
        .sts          (sts),
        .done         (done),
        .hit          (hit),
        .access_total (access_total),
        .miss_total   (miss_total)
    );

endmodule

`default_nettype wire

### rtl/core/lrufac_checker.sv
// lrufac_checker: port-level assertions for the lru cache core, with its bind
// depends on lrufac_pkg and lru_fully_associative_cache_core
`default_nettype none

module lrufac_checker #(
    parameter int COUNT_BITS = 32
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         done,
    input wire logic                         hit,
    input wire logic [lrufac_pkg::OUT_W-1:0] access_total,
    input wire logic [lrufac_pkg::OUT_W-1:0] miss_total
);

    // an accepted word always occupies the core
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepting a word");

    // a result only comes out of a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    // results are single-cycle and never back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // zero accesses means a clear result
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((COUNT_BITS <= lrufac_pkg::OUT_W) && done && (access_total == '0)) |->
        (!hit && (miss_total == '0)))
        else $error("clear result carries a hit or misses");

endmodule

bind lru_fully_associative_cache_core lrufac_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_lrufac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .hit          (hit),
    .access_total (access_total),
    .miss_total   (miss_total)
);

`default_nettype wire
